FILE: design/gql_pkg.sv
// ----------------------------------------------------------------------------
// gql_pkg
// Shared types and constants of the glyph quad layout block: configuration
// register map, queued command format and divider request/response.
// ----------------------------------------------------------------------------
package gql_pkg;

    localparam int CP_BITS        = 32;
    localparam int ATLAS_POS_BITS = 12;
    localparam int METRIC_BITS    = 10;
    localparam int POS_BITS       = 13;
    localparam int SIZE_BITS      = 13;
    localparam int TEX_BITS       = 17;
    localparam int COLOR_BITS     = 16;
    localparam int OUT_COORD_BITS = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int VERTS          = 6;
    localparam int VIDX_BITS      = 3;

    localparam logic [CP_BITS-1:0] CP_MAX     = 32'h0010_FFFF;
    localparam logic [CP_BITS-1:0] CP_NEWLINE = 32'd10;

    localparam logic [TEX_BITS-1:0]    TEX_MAX          = '1;
    localparam logic [METRIC_BITS-1:0] ROW_PITCH_RESET  = 10'd16;
    localparam logic [SIZE_BITS-1:0]   ATLAS_SIZE_RESET = 13'd256;
    localparam logic [COLOR_BITS-1:0]  COLOR_RESET      = 16'hFFFF;

    // Corner pattern of the six vertices: TL, TR, BL, BL, TR, BR
    localparam logic [VERTS-1:0] RIGHT_MASK  = 6'b110010;
    localparam logic [VERTS-1:0] BOTTOM_MASK = 6'b101100;
    localparam logic [VIDX_BITS-1:0] LAST_VIDX = VIDX_BITS'(VERTS - 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROW_PITCH    = 3'd0,
        REG_ATLAS_WIDTH  = 3'd1,
        REG_ATLAS_HEIGHT = 3'd2,
        REG_TEXT_RED     = 3'd3,
        REG_TEXT_GREEN   = 3'd4,
        REG_TEXT_BLUE    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_U0 = 2'd0,
        DIV_U1 = 2'd1,
        DIV_V0 = 2'd2,
        DIV_V1 = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic [METRIC_BITS-1:0] row_pitch;
        logic [SIZE_BITS-1:0]   atlas_width;
        logic [SIZE_BITS-1:0]   atlas_height;
        logic [COLOR_BITS-1:0]  red;
        logic [COLOR_BITS-1:0]  green;
        logic [COLOR_BITS-1:0]  blue;
    } cfg_t;

    typedef struct packed {
        logic                      is_newline;
        logic [ATLAS_POS_BITS-1:0] gx;
        logic [ATLAS_POS_BITS-1:0] gy;
        logic [METRIC_BITS-1:0]    gw;
        logic [METRIC_BITS-1:0]    gh;
        logic [METRIC_BITS-1:0]    xoff;
        logic [METRIC_BITS-1:0]    yoff;
        logic [METRIC_BITS-1:0]    adv;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        logic                 start;
        logic [POS_BITS-1:0]  pos;
        logic [SIZE_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [TEX_BITS-1:0] quot;
    } div_rsp_t;

endpackage

FILE: design/glyph_quad_layout_core.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_core
// Lays out one textured quad (six vertices) per in-range non-newline code point.
//
// Input channel (in_valid / in_stall): one code point plus its glyph metrics
// per request. Code points above U+10FFFF are dropped; a newline returns the
// pen to column zero and moves it down by the row pitch; every other code
// point yields six vertices TL, TR, BL, BL, TR, BR, the last one flagged.
// Output channel (out_valid / out_stall): one vertex per request from an
// output register; while the receiver stalls the vertex holds, and the front
// keeps taking requests until its two-entry queue fills.
// A glyph holds the back end through its pop, four texture divisions on the
// single shared divider (shorter when the coordinate saturates), then the
// emission of its six vertices, which a stalled receiver holds up. A newline
// holds the back end only for its pop; a dropped code point is accepted but
// never queued. Configuration (cfg_we / cfg_index / cfg_data) is written by
// the user only while idle; the block itself does not enforce this.
// Reset clears the pen to (0, 0), empties the queue and loads the register
// defaults: row pitch 16, atlas 256 x 256, white text.
// ----------------------------------------------------------------------------
module glyph_quad_layout_core
    import gql_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CP_BITS-1:0]            code_point,
    input  logic [ATLAS_POS_BITS-1:0]     glyph_x,
    input  logic [ATLAS_POS_BITS-1:0]     glyph_y,
    input  logic [METRIC_BITS-1:0]        glyph_w,
    input  logic [METRIC_BITS-1:0]        glyph_h,
    input  logic signed [METRIC_BITS-1:0] glyph_xoff,
    input  logic signed [METRIC_BITS-1:0] glyph_yoff,
    input  logic [METRIC_BITS-1:0]        glyph_advance,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_COORD_BITS-1:0] vertex_x,
    output logic signed [OUT_COORD_BITS-1:0] vertex_y,
    output logic [TEX_BITS-1:0]           tex_u,
    output logic [TEX_BITS-1:0]           tex_v,
    output logic [COLOR_BITS-1:0]         vertex_red,
    output logic [COLOR_BITS-1:0]         vertex_green,
    output logic [COLOR_BITS-1:0]         vertex_blue,
    output logic                          last_vertex
);

    cfg_t     cfg_reg, cfg_next;
    q_head_t  q_head;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Register file: indexes beyond the map are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_PITCH:    cfg_next.row_pitch    = cfg_data[METRIC_BITS-1:0];
                REG_ATLAS_WIDTH:  cfg_next.atlas_width  = cfg_data[SIZE_BITS-1:0];
                REG_ATLAS_HEIGHT: cfg_next.atlas_height = cfg_data[SIZE_BITS-1:0];
                REG_TEXT_RED:     cfg_next.red          = cfg_data[COLOR_BITS-1:0];
                REG_TEXT_GREEN:   cfg_next.green        = cfg_data[COLOR_BITS-1:0];
                REG_TEXT_BLUE:    cfg_next.blue         = cfg_data[COLOR_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_pitch    <= ROW_PITCH_RESET;
            cfg_reg.atlas_width  <= ATLAS_SIZE_RESET;
            cfg_reg.atlas_height <= ATLAS_SIZE_RESET;
            cfg_reg.red          <= COLOR_RESET;
            cfg_reg.green        <= COLOR_RESET;
            cfg_reg.blue         <= COLOR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept, classify, queue.
    gql_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_point    (code_point),
        .glyph_x       (glyph_x),
        .glyph_y       (glyph_y),
        .glyph_w       (glyph_w),
        .glyph_h       (glyph_h),
        .glyph_xoff    (glyph_xoff),
        .glyph_yoff    (glyph_yoff),
        .glyph_advance (glyph_advance),
        .q_pop         (q_pop),
        .q_head        (q_head)
    );

    // Shared texture coordinate divider.
    gql_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back: pen update, corners, texture, vertex stream.
    gql_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_red   (vertex_red),
        .vertex_green (vertex_green),
        .vertex_blue  (vertex_blue),
        .last_vertex  (last_vertex)
    );

endmodule

FILE: design/gql_div.sv
// ----------------------------------------------------------------------------
// gql_div
// Restoring divider for texture coordinates: floor(pos * 65536 / den),
// saturated to Q1.16 full scale, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gql_div
    import gql_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(TEX_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic [SIZE_BITS-1:0] den_reg, den_next;
    logic [TEX_BITS-1:0]  nb_reg, nb_next;
    logic [TEX_BITS-1:0]  quot_reg, quot_next;

    logic                 sat;
    logic [SIZE_BITS:0]   trial;
    logic [SIZE_BITS:0]   diff;
    logic                 fits;

    // quotient overflows Q1.16 exactly when pos >= 2 * den
    assign sat   = {1'b0, req.pos} >= {req.den, 1'b0};
    assign trial = {rem_reg, nb_reg[TEX_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        nb_next   = nb_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            den_next = req.den;
            if (sat)
            begin
                quot_next = TEX_MAX;
                done_next = 1'b1;
            end
            else
            begin
                // top part of pos << 16 already below den
                rem_next  = {1'b0, req.pos[POS_BITS-1:1]};
                nb_next   = {req.pos[0], {(TEX_BITS-1){1'b0}}};
                quot_next = '0;
                cnt_next  = CNT_BITS'(TEX_BITS);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
            quot_next = {quot_reg[TEX_BITS-2:0], fits};
            nb_next   = {nb_reg[TEX_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        nb_reg   <= nb_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(req.start) || $past(busy_reg)))
        else $error("divider done without a running division");

endmodule

FILE: design/gql_front.sv
// ----------------------------------------------------------------------------
// gql_front
// Input side: accept code points, drop out-of-range ones, tag newlines and
// hold commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module gql_front
    import gql_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CP_BITS-1:0]        code_point,
    input  logic [ATLAS_POS_BITS-1:0] glyph_x,
    input  logic [ATLAS_POS_BITS-1:0] glyph_y,
    input  logic [METRIC_BITS-1:0]    glyph_w,
    input  logic [METRIC_BITS-1:0]    glyph_h,
    input  logic signed [METRIC_BITS-1:0] glyph_xoff,
    input  logic signed [METRIC_BITS-1:0] glyph_yoff,
    input  logic [METRIC_BITS-1:0]    glyph_advance,
    input  logic                      q_pop,
    output q_head_t                   q_head
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    cmd_t push_cmd;
    logic accept;
    logic push;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        ptr_inc = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
    endfunction

    assign in_stall = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    // drop code points beyond the Unicode range
    assign push     = accept && (code_point <= CP_MAX);

    always_comb
    begin
        push_cmd.is_newline = (code_point == CP_NEWLINE);
        push_cmd.gx         = glyph_x;
        push_cmd.gy         = glyph_y;
        push_cmd.gw         = glyph_w;
        push_cmd.gh         = glyph_h;
        push_cmd.xoff       = glyph_xoff;
        push_cmd.yoff       = glyph_yoff;
        push_cmd.adv        = glyph_advance;
    end

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = q_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        case ({push, q_pop})
            2'b10:   cnt_next = cnt_reg + CNT_BITS'(1);
            2'b01:   cnt_next = cnt_reg - CNT_BITS'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign q_head.valid = (cnt_reg != '0);
    assign q_head.cmd   = slot_reg[rd_ptr_reg];

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (cnt_reg != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: design/gql_back.sv
// ----------------------------------------------------------------------------
// gql_back
// Execution side: pen state, quad corner arithmetic with saturation, four
// texture divisions per glyph and the output register for its six vertices.
// ----------------------------------------------------------------------------
module gql_back
    import gql_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  q_head_t                      q_head,
    output logic                         q_pop,
    output div_req_t                     div_req,
    input  div_rsp_t                     div_rsp,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [OUT_COORD_BITS-1:0] vertex_x,
    output logic signed [OUT_COORD_BITS-1:0] vertex_y,
    output logic [TEX_BITS-1:0]          tex_u,
    output logic [TEX_BITS-1:0]          tex_v,
    output logic [COLOR_BITS-1:0]        vertex_red,
    output logic [COLOR_BITS-1:0]        vertex_green,
    output logic [COLOR_BITS-1:0]        vertex_blue,
    output logic                         last_vertex
);

    localparam int WIDE = COORD_BITS + 4;
    localparam logic signed [WIDE-1:0] SAT_HI =
        WIDE'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_DIV_START = 4'b0010,
        S_DIV_WAIT  = 4'b0100,
        S_EMIT      = 4'b1000
    } state_t;

    function automatic logic signed [WIDE-1:0] sat_coord(input logic signed [WIDE-1:0] v);
        if (v > SAT_HI)
            sat_coord = SAT_HI;
        else if (v < SAT_LO)
            sat_coord = SAT_LO;
        else
            sat_coord = v;
    endfunction

    state_t                        state_reg, state_next;
    div_sel_t                      div_idx_reg, div_idx_next;
    logic [VIDX_BITS-1:0]          vidx_reg, vidx_next;
    logic signed [COORD_BITS-1:0]  pen_x_reg, pen_x_next;
    logic signed [COORD_BITS-1:0]  pen_y_reg, pen_y_next;
    logic                          out_valid_reg, out_valid_next;

    logic [OUT_COORD_BITS-1:0]     xl_reg, xr_reg, yt_reg, yb_reg;
    logic [ATLAS_POS_BITS-1:0]     gx_reg, gy_reg;
    logic [METRIC_BITS-1:0]        gw_reg, gh_reg, adv_reg;
    logic [TEX_BITS-1:0]           u0_reg, u1_reg, v0_reg, v1_reg;
    logic [OUT_COORD_BITS-1:0]     vx_reg, vy_reg;
    logic [TEX_BITS-1:0]           tu_reg, tv_reg;
    logic [COLOR_BITS-1:0]         red_reg, green_reg, blue_reg;
    logic                          last_reg;

    logic signed [WIDE-1:0] px_w, py_w, xoff_w, yoff_w, gw_w, gh_w, lh_w, adv_w;
    logic signed [WIDE-1:0] xl_raw, xr_raw, yt_raw, yb_raw;
    logic signed [WIDE-1:0] xl_sat, xr_sat, yt_sat, yb_sat;
    logic signed [WIDE-1:0] pen_y_nl, pen_x_adv;
    logic                   out_load;
    logic                   right, bottom;
    logic [SIZE_BITS-1:0]   den_raw;

    // corner arithmetic on the command at the head of the queue
    assign px_w   = WIDE'(pen_x_reg);
    assign py_w   = WIDE'(pen_y_reg);
    assign xoff_w = WIDE'($signed(q_head.cmd.xoff));
    assign yoff_w = WIDE'($signed(q_head.cmd.yoff));
    assign gw_w   = $signed({{(WIDE-METRIC_BITS){1'b0}}, q_head.cmd.gw});
    assign gh_w   = $signed({{(WIDE-METRIC_BITS){1'b0}}, q_head.cmd.gh});
    assign lh_w   = $signed({{(WIDE-METRIC_BITS){1'b0}}, cfg.row_pitch});
    assign adv_w  = $signed({{(WIDE-METRIC_BITS){1'b0}}, adv_reg});

    assign xl_raw = px_w + xoff_w;
    assign xr_raw = xl_raw + gw_w;
    assign yt_raw = -(py_w + yoff_w);
    assign yb_raw = yt_raw - gh_w;

    // each corner saturates from its exact sum
    assign xl_sat    = sat_coord(xl_raw);
    assign xr_sat    = sat_coord(xr_raw);
    assign yt_sat    = sat_coord(yt_raw);
    assign yb_sat    = sat_coord(yb_raw);
    assign pen_y_nl  = sat_coord(py_w + lh_w);
    assign pen_x_adv = sat_coord(px_w + adv_w);

    assign q_pop = (state_reg == S_IDLE) && q_head.valid;

    // divisor of zero counts as one
    assign den_raw = (div_idx_reg == DIV_V0 || div_idx_reg == DIV_V1) ?
                     cfg.atlas_height : cfg.atlas_width;

    always_comb
    begin
        div_req.start = (state_reg == S_DIV_START);
        div_req.den   = (den_raw == '0) ? SIZE_BITS'(1) : den_raw;
        case (div_idx_reg)
            DIV_U0:  div_req.pos = POS_BITS'(gx_reg);
            DIV_U1:  div_req.pos = POS_BITS'(gx_reg) + POS_BITS'(gw_reg);
            DIV_V0:  div_req.pos = POS_BITS'(gy_reg);
            DIV_V1:  div_req.pos = POS_BITS'(gy_reg) + POS_BITS'(gh_reg);
            default: div_req.pos = POS_BITS'(gx_reg);
        endcase
    end

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign right    = RIGHT_MASK[vidx_reg];
    assign bottom   = BOTTOM_MASK[vidx_reg];

    always_comb
    begin
        state_next     = state_reg;
        div_idx_next   = div_idx_reg;
        vidx_next      = vidx_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (q_head.valid)
                begin
                    if (q_head.cmd.is_newline)
                    begin
                        pen_x_next = '0;
                        pen_y_next = pen_y_nl[COORD_BITS-1:0];
                    end
                    else
                    begin
                        div_idx_next = DIV_U0;
                        state_next   = S_DIV_START;
                    end
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_idx_reg == DIV_V1)
                    begin
                        vidx_next  = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_idx_next = div_sel_t'(div_idx_reg + 2'd1);
                        state_next   = S_DIV_START;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (vidx_reg == LAST_VIDX)
                    begin
                        pen_x_next = pen_x_adv[COORD_BITS-1:0];
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        vidx_next = vidx_reg + VIDX_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_idx_reg   <= DIV_U0;
            vidx_reg      <= '0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_idx_reg   <= div_idx_next;
            vidx_reg      <= vidx_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_head.cmd.is_newline)
        begin
            xl_reg  <= xl_sat[OUT_COORD_BITS-1:0];
            xr_reg  <= xr_sat[OUT_COORD_BITS-1:0];
            yt_reg  <= yt_sat[OUT_COORD_BITS-1:0];
            yb_reg  <= yb_sat[OUT_COORD_BITS-1:0];
            gx_reg  <= q_head.cmd.gx;
            gy_reg  <= q_head.cmd.gy;
            gw_reg  <= q_head.cmd.gw;
            gh_reg  <= q_head.cmd.gh;
            adv_reg <= q_head.cmd.adv;
        end
        if ((state_reg == S_DIV_WAIT) && div_rsp.done)
        begin
            case (div_idx_reg)
                DIV_U0:  u0_reg <= div_rsp.quot;
                DIV_U1:  u1_reg <= div_rsp.quot;
                DIV_V0:  v0_reg <= div_rsp.quot;
                DIV_V1:  v1_reg <= div_rsp.quot;
                default: u0_reg <= div_rsp.quot;
            endcase
        end
        if (out_load)
        begin
            vx_reg    <= right ? xr_reg : xl_reg;
            vy_reg    <= bottom ? yb_reg : yt_reg;
            tu_reg    <= right ? u1_reg : u0_reg;
            tv_reg    <= bottom ? v1_reg : v0_reg;
            red_reg   <= cfg.red;
            green_reg <= cfg.green;
            blue_reg  <= cfg.blue;
            last_reg  <= (vidx_reg == LAST_VIDX);
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_x     = $signed(vx_reg);
    assign vertex_y     = $signed(vy_reg);
    assign tex_u        = tu_reg;
    assign tex_v        = tv_reg;
    assign vertex_red   = red_reg;
    assign vertex_green = green_reg;
    assign vertex_blue  = blue_reg;
    assign last_vertex  = last_reg;

    a_vidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vidx_reg <= LAST_VIDX)
        else $error("vertex index beyond the sixth vertex");

    a_div_free_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("division requested while the divider is busy");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for glyph_quad_layout_core. An in-bench model tracks
// the pen position and the register settings, expands each accepted glyph
// request into its six expected vertices and checks each vertex the block
// returns, field by field. Directed corner cases run first. Random traffic
// follows under several idle and stall mixes; a run to the pen limits is last.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gql_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 100;
    localparam int RANDOM_PER_PHASE = 27;
    localparam longint COORD_MAX    = 32767;
    localparam longint COORD_MIN    = -32768;

    typedef struct {
        logic [CP_BITS-1:0]            cp;
        logic [ATLAS_POS_BITS-1:0]     gx;
        logic [ATLAS_POS_BITS-1:0]     gy;
        logic [METRIC_BITS-1:0]        w;
        logic [METRIC_BITS-1:0]        h;
        logic signed [METRIC_BITS-1:0] xoff;
        logic signed [METRIC_BITS-1:0] yoff;
        logic [METRIC_BITS-1:0]        adv;
    } glyph_req_t;

    typedef struct {
        logic signed [OUT_COORD_BITS-1:0] x;
        logic signed [OUT_COORD_BITS-1:0] y;
        logic [TEX_BITS-1:0]              u;
        logic [TEX_BITS-1:0]              v;
        logic [COLOR_BITS-1:0]            red;
        logic [COLOR_BITS-1:0]            green;
        logic [COLOR_BITS-1:0]            blue;
        logic                             last;
    } vertex_t;

    // Pen tracker and queue of vertices still owed by the block.
    class vertex_ledger;
        logic [METRIC_BITS-1:0] line_h;
        logic [SIZE_BITS-1:0]   atlas_w;
        logic [SIZE_BITS-1:0]   atlas_h;
        logic [COLOR_BITS-1:0]  red;
        logic [COLOR_BITS-1:0]  green;
        logic [COLOR_BITS-1:0]  blue;
        longint                 pen_x;
        longint                 pen_y;
        vertex_t                owed[$];
        int                     failures;
        int                     checked;
        int                     glyphs;
        int                     newlines;
        int                     dropped;

        function new();
            line_h  = ROW_PITCH_RESET;
            atlas_w = ATLAS_SIZE_RESET;
            atlas_h = ATLAS_SIZE_RESET;
            red     = COLOR_RESET;
            green   = COLOR_RESET;
            blue    = COLOR_RESET;
            pen_x   = 0;
            pen_y   = 0;
        endfunction

        function void apply_config(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_ROW_PITCH:    line_h  = val[METRIC_BITS-1:0];
                REG_ATLAS_WIDTH:  atlas_w = val[SIZE_BITS-1:0];
                REG_ATLAS_HEIGHT: atlas_h = val[SIZE_BITS-1:0];
                REG_TEXT_RED:     red     = val;
                REG_TEXT_GREEN:   green   = val;
                REG_TEXT_BLUE:    blue    = val;
                default: ;
            endcase
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_MAX)
                return COORD_MAX;
            if (v < COORD_MIN)
                return COORD_MIN;
            return v;
        endfunction

        // Unsigned Q1.16 of pos / size, truncated; a zero size counts as one.
        function logic [TEX_BITS-1:0] tex_fraction(longint pos, longint size);
            longint q;
            if (size == 0)
                size = 1;
            q = (pos << 16) / size;
            if (q > longint'(TEX_MAX))
                return TEX_MAX;
            return q[TEX_BITS-1:0];
        endfunction

        function void layout_glyph(glyph_req_t r);
            longint  xo, yo, w, h, gx, gy, lh, adv;
            longint  xl, xr, yt, yb;
            logic [TEX_BITS-1:0] u0, u1, v0, v1;
            vertex_t vx;
            bit      right, bottom;
            if (r.cp > CP_MAX)
            begin
                dropped++;
                return;
            end
            if (r.cp == CP_NEWLINE)
            begin
                newlines++;
                lh    = longint'(line_h);
                pen_x = 0;
                pen_y = clamp_coord(pen_y + lh);
                return;
            end
            glyphs++;
            xo  = longint'(r.xoff);
            yo  = longint'(r.yoff);
            w   = longint'(r.w);
            h   = longint'(r.h);
            gx  = longint'(r.gx);
            gy  = longint'(r.gy);
            adv = longint'(r.adv);
            // Corners clamp from the exact sums, not from each other.
            xl = clamp_coord(pen_x + xo);
            xr = clamp_coord(pen_x + xo + w);
            yt = clamp_coord(-(pen_y + yo));
            yb = clamp_coord(-(pen_y + yo) - h);
            u0 = tex_fraction(gx, longint'(atlas_w));
            u1 = tex_fraction(gx + w, longint'(atlas_w));
            v0 = tex_fraction(gy, longint'(atlas_h));
            v1 = tex_fraction(gy + h, longint'(atlas_h));
            // Corner order: TL, TR, BL, BL, TR, BR.
            for (int i = 0; i < VERTS; i++)
            begin
                right    = (i == 1) || (i == 4) || (i == 5);
                bottom   = (i == 2) || (i == 3) || (i == 5);
                vx.x     = OUT_COORD_BITS'(right ? xr : xl);
                vx.y     = OUT_COORD_BITS'(bottom ? yb : yt);
                vx.u     = right ? u1 : u0;
                vx.v     = bottom ? v1 : v0;
                vx.red   = red;
                vx.green = green;
                vx.blue  = blue;
                vx.last  = (i == VERTS - 1);
                owed.push_back(vx);
            end
            pen_x = clamp_coord(pen_x + adv);
        endfunction

        function void compare(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void match_vertex(vertex_t got);
            vertex_t want;
            if (owed.size() == 0)
            begin
                $error("vertex with nothing owed: x %0d y %0d", got.x, got.y);
                failures++;
                return;
            end
            want = owed.pop_front();
            checked++;
            compare("vertex_x", want.x, got.x);
            compare("vertex_y", want.y, got.y);
            compare("tex_u", want.u, got.u);
            compare("tex_v", want.v, got.v);
            compare("vertex_red", want.red, got.red);
            compare("vertex_green", want.green, got.green);
            compare("vertex_blue", want.blue, got.blue);
            compare("last_vertex", want.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0]        cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]         cfg_data      = '0;
    logic                             in_valid      = 1'b0;
    logic                             in_stall;
    logic [CP_BITS-1:0]               code_point    = '0;
    logic [ATLAS_POS_BITS-1:0]        glyph_x       = '0;
    logic [ATLAS_POS_BITS-1:0]        glyph_y       = '0;
    logic [METRIC_BITS-1:0]           glyph_w       = '0;
    logic [METRIC_BITS-1:0]           glyph_h       = '0;
    logic signed [METRIC_BITS-1:0]    glyph_xoff    = '0;
    logic signed [METRIC_BITS-1:0]    glyph_yoff    = '0;
    logic [METRIC_BITS-1:0]           glyph_advance = '0;
    logic                             out_valid;
    logic                             out_stall     = 1'b0;
    logic signed [OUT_COORD_BITS-1:0] vertex_x;
    logic signed [OUT_COORD_BITS-1:0] vertex_y;
    logic [TEX_BITS-1:0]              tex_u;
    logic [TEX_BITS-1:0]              tex_v;
    logic [COLOR_BITS-1:0]            vertex_red;
    logic [COLOR_BITS-1:0]            vertex_green;
    logic [COLOR_BITS-1:0]            vertex_blue;
    logic                             last_vertex;

    vertex_ledger ledger = new();
    int unsigned  cycle_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    glyph_quad_layout_core uut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a missing vertex ends up here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Vertex sink. Sample at the edge (pre-update values), then pick the
    // stall for the next cycle at random per the current mix.
    initial
    begin : vertex_sink
        vertex_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.x     = vertex_x;
                got.y     = vertex_y;
                got.u     = tex_u;
                got.v     = tex_v;
                got.red   = vertex_red;
                got.green = vertex_green;
                got.blue  = vertex_blue;
                got.last  = last_vertex;
                ledger.match_vertex(got);
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic glyph_req_t glyph(logic [CP_BITS-1:0] cp, int gx, int gy,
                                         int w, int h, int xo, int yo, int adv);
        glyph_req_t r;
        r.cp   = cp;
        r.gx   = ATLAS_POS_BITS'(gx);
        r.gy   = ATLAS_POS_BITS'(gy);
        r.w    = METRIC_BITS'(w);
        r.h    = METRIC_BITS'(h);
        r.xoff = METRIC_BITS'(xo);
        r.yoff = METRIC_BITS'(yo);
        r.adv  = METRIC_BITS'(adv);
        return r;
    endfunction

    // Mostly in-range glyphs; some newlines and some out-of-range code points.
    function automatic glyph_req_t random_request();
        glyph_req_t  r;
        int unsigned roll;
        r = glyph($urandom_range(32'h0010_FFFF, 0),
                  $urandom_range(4095, 0), $urandom_range(4095, 0),
                  $urandom_range(1023, 0), $urandom_range(1023, 0),
                  $urandom_range(1023, 0), $urandom_range(1023, 0),
                  $urandom_range(1023, 0));
        roll = $urandom_range(99);
        if (roll < 10)
            r.cp = CP_NEWLINE;
        else if (roll < 18)
            r.cp = $urandom_range(32'hFFFF_FFFF, 32'h0011_0000);
        return r;
    endfunction

    // Present one request and hold it until accepted. Valid stays high on
    // return; the next request or a drain decides what it does next.
    task automatic push_request(glyph_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        code_point    <= r.cp;
        glyph_x       <= r.gx;
        glyph_y       <= r.gy;
        glyph_w       <= r.w;
        glyph_h       <= r.h;
        glyph_xoff    <= r.xoff;
        glyph_yoff    <= r.yoff;
        glyph_advance <= r.adv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.layout_glyph(r);
    endtask

    // Stop sending, wait for every owed vertex, then let any queued newline
    // or dropped code point drain through the block.
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the task returns only after the enable has dropped.
    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_BITS-1:0];
        @(posedge clk);
        ledger.apply_config(idx, val[CFG_DATA_BITS-1:0]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_settings();
        write_reg(REG_ROW_PITCH, $urandom_range(63, 0));
        write_reg(REG_ATLAS_WIDTH, $urandom_range(4096, 1));
        write_reg(REG_ATLAS_HEIGHT, $urandom_range(4096, 1));
        write_reg(REG_TEXT_RED, $urandom_range(65535, 0));
        write_reg(REG_TEXT_GREEN, $urandom_range(65535, 0));
        write_reg(REG_TEXT_BLUE, $urandom_range(65535, 0));
    endtask

    initial
    begin : stimulus
        int         send_mix[4];
        int         stall_mix[4];
        glyph_req_t req;

        send_mix  = '{0, 59, 0, 20};
        stall_mix = '{0, 0, 59, 20};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, register defaults: zero and full-scale metrics, top
        // code point, code point zero, dropped code points, newlines.
        push_request(glyph(65, 0, 0, 0, 0, 0, 0, 0));
        push_request(glyph(0, 4095, 4095, 1023, 1023, 511, 511, 1023));
        push_request(glyph(CP_MAX, 16, 32, 8, 12, -512, -512, 9));
        push_request(glyph(CP_MAX + 1, 1, 2, 3, 4, 5, 6, 7));
        push_request(glyph(32'hFFFF_FFFF, 4095, 4095, 1023, 1023, -1, -1, 1023));
        push_request(glyph(CP_NEWLINE, 7, 7, 7, 7, 7, 7, 7));
        push_request(glyph(66, 128, 64, 10, 14, -1, -3, 11));
        push_request(glyph(CP_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
        push_request(glyph(CP_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
        push_request(glyph(67, 200, 100, 20, 30, 4, -6, 22));

        // Tallest line, narrowest and widest atlas, mixed colors.
        drain_block();
        write_reg(REG_ROW_PITCH, 1023);
        write_reg(REG_ATLAS_WIDTH, 1);
        write_reg(REG_ATLAS_HEIGHT, 4096);
        write_reg(REG_TEXT_RED, 0);
        write_reg(REG_TEXT_GREEN, 16'hFFFF);
        write_reg(REG_TEXT_BLUE, 16'h1234);
        push_request(glyph(68, 0, 4095, 1, 1, 3, 3, 5));
        push_request(glyph(CP_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
        push_request(glyph(69, 2, 2048, 0, 1023, -100, 100, 40));

        // Zero row pitch, swapped atlas extremes.
        drain_block();
        write_reg(REG_ROW_PITCH, 0);
        write_reg(REG_ATLAS_WIDTH, 4096);
        write_reg(REG_ATLAS_HEIGHT, 1);
        write_reg(REG_TEXT_RED, 16'hFFFF);
        write_reg(REG_TEXT_GREEN, 0);
        write_reg(REG_TEXT_BLUE, 0);
        push_request(glyph(CP_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
        push_request(glyph(70, 4095, 0, 1023, 0, 0, 0, 1));

        // Zero atlas size acts as one.
        drain_block();
        write_reg(REG_ATLAS_WIDTH, 0);
        write_reg(REG_ATLAS_HEIGHT, 0);
        push_request(glyph(71, 1, 0, 0, 0, 0, 0, 2));
        push_request(glyph(72, 0, 1, 1, 0, 1, 1, 3));

        // Sizes that leave a remainder.
        drain_block();
        write_reg(REG_ATLAS_WIDTH, 3);
        write_reg(REG_ATLAS_HEIGHT, 7);
        push_request(glyph(73, 1, 2, 1, 3, -2, 2, 4));

        // Random traffic under each idle/stall mix, new settings per mix.
        for (int p = 0; p < 4; p++)
        begin
            drain_block();
            send_idle_pct  = send_mix[p];
            recv_stall_pct = stall_mix[p];
            random_settings();
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Once, hold off mid-stream until every vertex is back.
                if (p == 1 && n == RANDOM_PER_PHASE / 2)
                    drain_block();
                push_request(random_request());
            end
        end

        // Drive the pen to its limits last, since pen y never comes back.
        drain_block();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        write_reg(REG_ROW_PITCH, 1023);
        push_request(glyph(CP_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
        for (int n = 0; n < 34; n++)
        begin
            req     = random_request();
            req.cp  = $urandom_range(32'h0010_FFFF, 32'h20);
            req.adv = METRIC_BITS'($urandom_range(1023, 1000));
            push_request(req);
        end
        push_request(glyph(74, 10, 10, 1023, 1023, 511, -512, 1023));
        for (int n = 0; n < 33; n++)
            push_request(glyph(CP_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
        push_request(glyph(75, 10, 10, 1023, 1023, 511, 511, 1023));
        push_request(glyph(76, 20, 20, 5, 5, -512, -512, 0));
        for (int n = 0; n < 6; n++)
            push_request(random_request());

        drain_block();
        if (ledger.owed.size() != 0)
        begin
            $error("%0d vertices never arrived", ledger.owed.size());
            ledger.failures++;
        end

        $display("Covered %0d glyphs, %0d newlines and %0d dropped code points;",
                 ledger.glyphs, ledger.newlines, ledger.dropped);
        $display("%0d vertices checked over idle/stall mixes and pen saturation.",
                 ledger.checked);
        if (ledger.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
design/gql_pkg.sv
design/gql_div.sv
design/gql_front.sv
design/gql_back.sv
design/glyph_quad_layout_core.sv
bench/tb.sv
